// ===== sv/bfa_pkg.sv =====
// ----------------------------------------------------------------------------
// bfa_pkg: shared types and constants of the 3x3 border-aware box filter
// Pixel, column and stage payload types, sizes and the reciprocal table
// used to divide a neighborhood sum by its in-bounds pixel count.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int MAX_SIZE    = 1024;
  localparam int CH_W        = 8;
  localparam int NUM_CH      = 4;
  localparam int SIZE_W      = 11;
  localparam int COORD_W     = $clog2(MAX_SIZE);
  localparam int SUM_W       = CH_W + 4;
  localparam int CNT_W       = 4;
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = SUM_W + RECIP_W;
  localparam int LINE_W      = 2 * NUM_CH * CH_W;

  // Item kinds on the input channel.
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  // Channel 0 is red, then green, blue, alpha.
  typedef logic [NUM_CH-1:0][CH_W-1:0] pixel_t;

  // One window column: index 0 is the top row, 2 the bottom row.
  typedef logic [2:0][NUM_CH-1:0][CH_W-1:0] col_t;

  // One line store entry: the two rows above the incoming pixel.
  typedef struct packed {
    pixel_t top;
    pixel_t mid;
  } line_t;

  // Position of the item entering the window stage.
  typedef struct packed {
    logic               emit;
    logic               last;
    logic               top_ok;
    logic               bot_ok;
    logic               left_ok;
    logic               right_ok;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] addr;
  } pos_t;

  // Neighborhood sums handed to the divide stage.
  typedef struct packed {
    logic [NUM_CH-1:0][SUM_W-1:0] sums;
    logic [CNT_W-1:0]             cnt;
    logic [COORD_W-1:0]           row;
    logic [COORD_W-1:0]           col;
    logic                         last;
  } sum_t;

  // One finished result.
  typedef struct packed {
    pixel_t             mean;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
  } res_t;

  // Rounded-up reciprocal scaled by 2^RECIP_SHIFT. For every sum that can
  // occur the product shifted right gives the exact truncated quotient.
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
    logic [RECIP_W-1:0] r;
    unique case (cnt)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd6:    r = 17'd10923;
      4'd9:    r = 17'd7282;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/bfa_ifs.sv =====
// ----------------------------------------------------------------------------
// bfa_ifs: channel interfaces of the box filter
// Pixel input channel, result channel and the size configuration channel,
// each a valid/ready handshake with its payload.
// ----------------------------------------------------------------------------
interface bfa_in_if import bfa_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            req_type;
  logic [CH_W-1:0] red_in;
  logic [CH_W-1:0] green_in;
  logic [CH_W-1:0] blue_in;
  logic [CH_W-1:0] alpha_in;

  modport source(output valid, req_type, red_in, green_in, blue_in, alpha_in,
                 input ready);
  modport sink(input valid, req_type, red_in, green_in, blue_in, alpha_in,
               output ready);
endinterface

interface bfa_out_if import bfa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CH_W-1:0]    red_out;
  logic [CH_W-1:0]    green_out;
  logic [CH_W-1:0]    blue_out;
  logic [CH_W-1:0]    alpha_out;
  logic [COORD_W-1:0] out_row;
  logic [COORD_W-1:0] out_col;
  logic               frame_last;

  modport source(output valid, red_out, green_out, blue_out, alpha_out,
                 out_row, out_col, frame_last, input ready);
  modport sink(input valid, red_out, green_out, blue_out, alpha_out,
               out_row, out_col, frame_last, output ready);
endinterface

interface bfa_cfg_if import bfa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] image_size;

  modport source(output valid, image_size, input ready);
  modport sink(input valid, image_size, output ready);
endinterface

// ===== sv/bfa_line_ram.sv =====
// ----------------------------------------------------------------------------
// bfa_line_ram: simple dual-port line store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bfa_line_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/bfa_pos.sv =====
// ----------------------------------------------------------------------------
// bfa_pos: frame position tracking
// Holds the image size, counts stream beats in row and column form, filters
// out pixels and drains that do not belong, and derives the output position
// and the border flags of the neighborhood that the beat completes.
// ----------------------------------------------------------------------------
module bfa_pos import bfa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr,
  input  logic [SIZE_W-1:0] cfg_data,
  input  logic              in_acc,
  input  logic              req_type,
  output logic              take,
  output pos_t              pos
);

  logic [SIZE_W-1:0]  size_r, size_nxt;
  logic [SIZE_W-1:0]  row_r, row_nxt;
  logic [COORD_W-1:0] col_r, col_nxt;

  logic              pix_phase;
  logic              at_last;
  logic              col_wrap;
  logic              col_zero;
  logic [SIZE_W-1:0] out_r;
  logic [SIZE_W-1:0] out_c;

  always_comb begin
    pix_phase = row_r < size_r;
    take      = in_acc && ((req_type == REQ_PIXEL && pix_phase) ||
                           (req_type == REQ_DRAIN && !pix_phase));
    at_last   = row_r == size_r + SIZE_W'(1);
    col_wrap  = ({1'b0, col_r} + SIZE_W'(1)) == size_r;
    col_zero  = col_r == '0;

    // A beat at column zero closes the last column of the row two above.
    out_r = col_zero ? (row_r - SIZE_W'(2)) : (row_r - SIZE_W'(1));
    out_c = col_zero ? (size_r - SIZE_W'(1)) : ({1'b0, col_r} - SIZE_W'(1));

    pos.emit     = (row_r >= SIZE_W'(2)) || (row_r == SIZE_W'(1) && !col_zero);
    pos.last     = at_last;
    pos.top_ok   = out_r != '0;
    pos.bot_ok   = (out_r + SIZE_W'(1)) < size_r;
    pos.left_ok  = out_c != '0;
    pos.right_ok = !col_zero;
    pos.row      = out_r[COORD_W-1:0];
    pos.col      = out_c[COORD_W-1:0];
    pos.addr     = col_r;
  end

  always_comb begin
    size_nxt = size_r;
    row_nxt  = row_r;
    col_nxt  = col_r;
    if (cfg_wr) begin
      if (cfg_data == '0) begin
        size_nxt = SIZE_W'(1);
      end else if (cfg_data > SIZE_W'(MAX_SIZE)) begin
        size_nxt = SIZE_W'(MAX_SIZE);
      end else begin
        size_nxt = cfg_data;
      end
      row_nxt = '0;
      col_nxt = '0;
    end else if (take) begin
      if (at_last) begin
        row_nxt = '0;
        col_nxt = '0;
      end else if (col_wrap) begin
        row_nxt = row_r + SIZE_W'(1);
        col_nxt = '0;
      end else begin
        col_nxt = col_r + COORD_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_W'(MAX_SIZE);
      row_r  <= '0;
      col_r  <= '0;
    end else begin
      size_r <= size_nxt;
      row_r  <= row_nxt;
      col_r  <= col_nxt;
    end
  end

endmodule

// ===== sv/bfa_win.sv =====
// ----------------------------------------------------------------------------
// bfa_win: line store and 3x3 window stage
// Reads the two stored rows above each beat's column, writes them back one
// row down with the new pixel, shifts the window columns and sums the
// in-bounds neighborhood per channel.
// ----------------------------------------------------------------------------
module bfa_win import bfa_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   take,
  input  pixel_t pix_in,
  input  pos_t   pos_in,
  output logic   ld_ready,
  output logic   sum_valid,
  input  logic   sum_ready,
  output sum_t   sum_out
);

  logic   v1_r;
  pos_t   pos1_r;
  pixel_t pix1_r;
  logic   fwd_r;
  pixel_t fwd_top_r;
  pixel_t fwd_mid_r;
  col_t   prev1_r;
  col_t   prev2_r;

  line_t rd_line;
  line_t wr_line;
  col_t  new_col;
  logic  leave1;

  logic [2:0]                   row_ok;
  logic [2:0]                   col_ok;
  col_t [2:0]                   cols;
  logic [NUM_CH-1:0][SUM_W-1:0] sums;
  logic [1:0]                   n_rows;
  logic [1:0]                   n_cols;

  bfa_line_ram #(
    .WIDTH(LINE_W),
    .DEPTH(MAX_SIZE)
  ) u_ram (
    .clk  (clk),
    .we   (leave1),
    .waddr(pos1_r.addr),
    .wdata(wr_line),
    .re   (take),
    .raddr(pos_in.addr),
    .rdata(rd_line)
  );

  always_comb begin
    leave1    = v1_r && (!pos1_r.emit || sum_ready);
    ld_ready  = !v1_r || leave1;
    sum_valid = v1_r && pos1_r.emit;

    // The read data is stale when the previous beat wrote the same entry
    // in the cycle of the read: in a one-pixel row or at a frame restart.
    new_col[0] = fwd_r ? fwd_top_r : rd_line.top;
    new_col[1] = fwd_r ? fwd_mid_r : rd_line.mid;
    new_col[2] = pix1_r;

    wr_line.top = new_col[1];
    wr_line.mid = pix1_r;

    row_ok = {pos1_r.bot_ok, 1'b1, pos1_r.top_ok};
    col_ok = {pos1_r.right_ok, 1'b1, pos1_r.left_ok};
    cols   = {new_col, prev1_r, prev2_r};

    for (int ch = 0; ch < NUM_CH; ch++) begin
      sums[ch] = '0;
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          if (row_ok[r] && col_ok[c]) begin
            sums[ch] = sums[ch] + SUM_W'(cols[c][r][ch]);
          end
        end
      end
    end

    n_rows = 2'd1 + 2'(pos1_r.top_ok) + 2'(pos1_r.bot_ok);
    n_cols = 2'd1 + 2'(pos1_r.left_ok) + 2'(pos1_r.right_ok);

    sum_out.sums = sums;
    sum_out.cnt  = CNT_W'(n_rows) * CNT_W'(n_cols);
    sum_out.row  = pos1_r.row;
    sum_out.col  = pos1_r.col;
    sum_out.last = pos1_r.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (ld_ready) begin
      v1_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_ready && take) begin
      pos1_r    <= pos_in;
      pix1_r    <= pix_in;
      fwd_r     <= leave1 && (pos1_r.addr == pos_in.addr);
      fwd_top_r <= new_col[1];
      fwd_mid_r <= pix1_r;
    end
    if (leave1) begin
      prev2_r <= prev1_r;
      prev1_r <= new_col;
    end
  end

endmodule

// ===== sv/bfa_norm.sv =====
// ----------------------------------------------------------------------------
// bfa_norm: divide stage and result register
// Divides each channel sum by the neighborhood count through a reciprocal
// multiply and holds the finished result until the receiver takes it.
// ----------------------------------------------------------------------------
module bfa_norm import bfa_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic sum_valid,
  output logic sum_ready,
  input  sum_t sum_in,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  logic v2_r;
  sum_t s2_r;
  logic vo_r;
  res_t res_r;

  logic                          out_take;
  logic [RECIP_W-1:0]            rcp;
  logic [NUM_CH-1:0][PROD_W-1:0] prod;
  res_t                          res_nxt;

  always_comb begin
    out_take  = !vo_r || res_ready;
    sum_ready = !v2_r || out_take;
    rcp       = recip(s2_r.cnt);
    for (int ch = 0; ch < NUM_CH; ch++) begin
      prod[ch]             = PROD_W'(s2_r.sums[ch]) * PROD_W'(rcp);
      res_nxt.mean[ch]     = prod[ch][RECIP_SHIFT +: CH_W];
    end
    res_nxt.row  = s2_r.row;
    res_nxt.col  = s2_r.col;
    res_nxt.last = s2_r.last;
    res_valid    = vo_r;
    res          = res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (sum_ready) begin
        v2_r <= sum_valid;
      end
      if (out_take) begin
        vo_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sum_ready && sum_valid) begin
      s2_r <= sum_in;
    end
    if (out_take && v2_r) begin
      res_r <= res_nxt;
    end
  end

endmodule

// ===== sv/box_filter_3x3_border_avg.sv =====
// ----------------------------------------------------------------------------
// box_filter_3x3_border_avg: 3x3 mean filter over a square RGBA image
// Pixels arrive in raster order on in_chan; each result on out_chan is the
// truncated per-channel mean of the in-bounds 3x3 neighborhood with its
// row, column and a frame_last flag on the final pixel of the image.
//
// The result for raster position k is released by input beat k+size+1, so
// after the last pixel the source sends size+1 drain beats. A drain beat
// before all pixels arrived, or a pixel beat after, is taken and dropped.
// out_chan.valid rises once the beat that released a result has moved
// through the window and divide registers into the result register. One
// beat is accepted every cycle while out_chan does not stall; the rate is
// set by the line store, which does one read and one write per cycle.
// cfg_chan sets the image size (1 to 1024) and restarts the frame; write it
// only between frames. Reset sets the size to 1024 and empties the pipeline;
// the line store needs no clearing. When out_chan stalls, the result register
// holds its beat, the earlier stages fill behind it and in_chan.ready drops.
// ----------------------------------------------------------------------------
module box_filter_3x3_border_avg import bfa_pkg::*; (
  input logic          clk,
  input logic          rst_n,
  bfa_in_if.sink       in_chan,
  bfa_out_if.source    out_chan,
  bfa_cfg_if.sink      cfg_chan
);

  logic   take;
  pos_t   pos;
  pixel_t pix_in;
  logic   ld_ready;
  logic   sum_valid;
  logic   sum_ready;
  sum_t   sums;
  res_t   res;

  assign cfg_chan.ready = 1'b1;
  assign in_chan.ready  = ld_ready;

  assign pix_in[0] = in_chan.red_in;
  assign pix_in[1] = in_chan.green_in;
  assign pix_in[2] = in_chan.blue_in;
  assign pix_in[3] = in_chan.alpha_in;

  bfa_pos u_pos (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_wr  (cfg_chan.valid),
    .cfg_data(cfg_chan.image_size),
    .in_acc  (in_chan.valid && ld_ready),
    .req_type(in_chan.req_type),
    .take    (take),
    .pos     (pos)
  );

  bfa_win u_win (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .pix_in   (pix_in),
    .pos_in   (pos),
    .ld_ready (ld_ready),
    .sum_valid(sum_valid),
    .sum_ready(sum_ready),
    .sum_out  (sums)
  );

  bfa_norm u_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .sum_valid(sum_valid),
    .sum_ready(sum_ready),
    .sum_in   (sums),
    .res_valid(out_chan.valid),
    .res_ready(out_chan.ready),
    .res      (res)
  );

  assign out_chan.red_out    = res.mean[0];
  assign out_chan.green_out  = res.mean[1];
  assign out_chan.blue_out   = res.mean[2];
  assign out_chan.alpha_out  = res.mean[3];
  assign out_chan.out_row    = res.row;
  assign out_chan.out_col    = res.col;
  assign out_chan.frame_last = res.last;

endmodule
